@@ hw/rtl/sit_pkg.sv @@
// Package for the segment intersection test pipeline.
// Holds the coordinate and product types and the words passed between stages.
// No dependencies.
`timescale 1ns / 1ps

package sit_pkg;

    localparam int COORD_BITS = 16;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int VSUM_BITS  = PROD_BITS + 1;
    localparam int WIDE_BITS  = PROD_BITS + DIFF_BITS;
    localparam int SUM_BITS   = WIDE_BITS + 2;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_BITS-1:0]  t_diff;
    typedef logic signed [PROD_BITS-1:0]  t_prod;
    typedef logic signed [VSUM_BITS-1:0]  t_vsum;
    typedef logic signed [WIDE_BITS-1:0]  t_wide;
    typedef logic signed [SUM_BITS-1:0]   t_sum;

    typedef struct packed {
        t_coord ax0;
        t_coord ay0;
        t_coord ax1;
        t_coord ay1;
        t_coord bx0;
        t_coord by0;
        t_coord bx1;
        t_coord by1;
    } t_segs;

    typedef struct packed {
        logic disjoint;
        logic vert1;
        logic vert2;
        logic both_hit;
    } t_flags;

    typedef struct packed {
        t_flags flags;
        t_diff  dx1;
        t_diff  dx2;
        t_diff  dy1;
        t_diff  dy2;
        t_diff  dly;
        t_diff  ol1;
        t_diff  oh1;
        t_diff  ol2;
        t_diff  oh2;
        t_coord vly;
        t_coord vylo;
        t_coord vyhi;
        t_diff  vdx;
        t_diff  vdy;
        t_diff  voff;
    } t_span;

    typedef struct packed {
        t_flags flags;
        t_diff  dx1;
        t_diff  dx2;
        t_diff  dly;
        t_prod  p;
        t_prod  al;
        t_prod  bl;
        t_prod  ah;
        t_prod  bh;
        t_prod  vy;
        t_prod  vt;
        t_prod  vlo;
        t_prod  vhi;
    } t_prods;

    typedef struct packed {
        t_flags flags;
        t_wide  pd;
        t_wide  al2;
        t_wide  bl2;
        t_wide  ah2;
        t_wide  bh2;
        t_vsum  vsum;
        t_prod  vlo;
        t_prod  vhi;
    } t_wides;

endpackage

@@ hw/rtl/sit_setup.sv @@
// Front stages: order endpoints by x, form ranges and differences, select vertical case.
// Depends on sit_pkg.
`timescale 1ns / 1ps

module sit_setup (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  sit_pkg::t_segs i_segs,
    output logic          o_valid,
    output sit_pkg::t_span o_span
);

    typedef struct packed {
        sit_pkg::t_coord l1x;
        sit_pkg::t_coord l1y;
        sit_pkg::t_coord r1x;
        sit_pkg::t_coord r1y;
        sit_pkg::t_coord l2x;
        sit_pkg::t_coord l2y;
        sit_pkg::t_coord r2x;
        sit_pkg::t_coord r2y;
    } t_ends;

    typedef struct packed {
        logic            vert1;
        logic            vert2;
        logic            both_hit;
        sit_pkg::t_coord lo;
        sit_pkg::t_coord hi;
        sit_pkg::t_coord l1x;
        sit_pkg::t_coord l2x;
        sit_pkg::t_diff  dx1;
        sit_pkg::t_diff  dx2;
        sit_pkg::t_diff  dy1;
        sit_pkg::t_diff  dy2;
        sit_pkg::t_diff  dly;
        sit_pkg::t_coord vx;
        sit_pkg::t_coord vlx;
        sit_pkg::t_coord vly;
        sit_pkg::t_coord vylo;
        sit_pkg::t_coord vyhi;
        sit_pkg::t_diff  vdx;
        sit_pkg::t_diff  vdy;
    } t_setup;

    logic            r_v1, r_v2, r_v3;
    t_ends           r_ends, n_ends;
    t_setup          r_set, n_set;
    sit_pkg::t_span  r_span, n_span;

    sit_pkg::t_diff  dx1, dx2, dy1, dy2;
    sit_pkg::t_coord y1lo, y1hi, y2lo, y2hi, ov_lo, ov_hi;

    // order each segment by x
    always_comb begin
        if (i_segs.ax0 <= i_segs.ax1) begin
            n_ends.l1x = i_segs.ax0; n_ends.l1y = i_segs.ay0;
            n_ends.r1x = i_segs.ax1; n_ends.r1y = i_segs.ay1;
        end else begin
            n_ends.l1x = i_segs.ax1; n_ends.l1y = i_segs.ay1;
            n_ends.r1x = i_segs.ax0; n_ends.r1y = i_segs.ay0;
        end
        if (i_segs.bx0 <= i_segs.bx1) begin
            n_ends.l2x = i_segs.bx0; n_ends.l2y = i_segs.by0;
            n_ends.r2x = i_segs.bx1; n_ends.r2y = i_segs.by1;
        end else begin
            n_ends.l2x = i_segs.bx1; n_ends.l2y = i_segs.by1;
            n_ends.r2x = i_segs.bx0; n_ends.r2y = i_segs.by0;
        end
    end

    assign dx1 = sit_pkg::t_diff'(r_ends.r1x) - sit_pkg::t_diff'(r_ends.l1x);
    assign dx2 = sit_pkg::t_diff'(r_ends.r2x) - sit_pkg::t_diff'(r_ends.l2x);
    assign dy1 = sit_pkg::t_diff'(r_ends.r1y) - sit_pkg::t_diff'(r_ends.l1y);
    assign dy2 = sit_pkg::t_diff'(r_ends.r2y) - sit_pkg::t_diff'(r_ends.l2y);

    assign y1lo  = (r_ends.l1y < r_ends.r1y) ? r_ends.l1y : r_ends.r1y;
    assign y1hi  = (r_ends.l1y < r_ends.r1y) ? r_ends.r1y : r_ends.l1y;
    assign y2lo  = (r_ends.l2y < r_ends.r2y) ? r_ends.l2y : r_ends.r2y;
    assign y2hi  = (r_ends.l2y < r_ends.r2y) ? r_ends.r2y : r_ends.l2y;
    assign ov_lo = (y1lo > y2lo) ? y1lo : y2lo;
    assign ov_hi = (y1hi < y2hi) ? y1hi : y2hi;

    always_comb begin
        n_set.vert1    = (r_ends.l1x == r_ends.r1x);
        n_set.vert2    = (r_ends.l2x == r_ends.r2x);
        n_set.both_hit = (r_ends.l1x == r_ends.l2x) && (ov_lo <= ov_hi);
        n_set.lo       = (r_ends.l1x > r_ends.l2x) ? r_ends.l1x : r_ends.l2x;
        n_set.hi       = (r_ends.r1x < r_ends.r2x) ? r_ends.r1x : r_ends.r2x;
        n_set.l1x      = r_ends.l1x;
        n_set.l2x      = r_ends.l2x;
        n_set.dx1      = dx1;
        n_set.dx2      = dx2;
        n_set.dy1      = dy1;
        n_set.dy2      = dy2;
        n_set.dly      = sit_pkg::t_diff'(r_ends.l1y) - sit_pkg::t_diff'(r_ends.l2y);
        // vertical span from one segment, sloped line from the other
        if (r_ends.l1x == r_ends.r1x) begin
            n_set.vx   = r_ends.l1x;
            n_set.vylo = y1lo;
            n_set.vyhi = y1hi;
            n_set.vlx  = r_ends.l2x;
            n_set.vly  = r_ends.l2y;
            n_set.vdx  = dx2;
            n_set.vdy  = dy2;
        end else begin
            n_set.vx   = r_ends.l2x;
            n_set.vylo = y2lo;
            n_set.vyhi = y2hi;
            n_set.vlx  = r_ends.l1x;
            n_set.vly  = r_ends.l1y;
            n_set.vdx  = dx1;
            n_set.vdy  = dy1;
        end
    end

    always_comb begin
        n_span.flags.disjoint = (r_set.lo > r_set.hi);
        n_span.flags.vert1    = r_set.vert1;
        n_span.flags.vert2    = r_set.vert2;
        n_span.flags.both_hit = r_set.both_hit;
        n_span.dx1  = r_set.dx1;
        n_span.dx2  = r_set.dx2;
        n_span.dy1  = r_set.dy1;
        n_span.dy2  = r_set.dy2;
        n_span.dly  = r_set.dly;
        n_span.ol1  = sit_pkg::t_diff'(r_set.lo) - sit_pkg::t_diff'(r_set.l1x);
        n_span.oh1  = sit_pkg::t_diff'(r_set.hi) - sit_pkg::t_diff'(r_set.l1x);
        n_span.ol2  = sit_pkg::t_diff'(r_set.lo) - sit_pkg::t_diff'(r_set.l2x);
        n_span.oh2  = sit_pkg::t_diff'(r_set.hi) - sit_pkg::t_diff'(r_set.l2x);
        n_span.vly  = r_set.vly;
        n_span.vylo = r_set.vylo;
        n_span.vyhi = r_set.vyhi;
        n_span.vdx  = r_set.vdx;
        n_span.vdy  = r_set.vdy;
        n_span.voff = sit_pkg::t_diff'(r_set.vx) - sit_pkg::t_diff'(r_set.vlx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ends <= n_ends;
        r_set  <= n_set;
        r_span <= n_span;
    end

    assign o_valid = r_v3;
    assign o_span  = r_span;

endmodule

@@ hw/rtl/sit_arith.sv @@
// Multiplier stages: pairwise products, then third factor and vertical sum.
// Depends on sit_pkg.
`timescale 1ns / 1ps

module sit_arith (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  sit_pkg::t_span  i_span,
    output logic            o_valid,
    output sit_pkg::t_wides o_wides
);

    logic             r_v4, r_v5;
    sit_pkg::t_prods  r_prods, n_prods;
    sit_pkg::t_wides  r_wides, n_wides;

    always_comb begin
        n_prods.flags = i_span.flags;
        n_prods.dx1   = i_span.dx1;
        n_prods.dx2   = i_span.dx2;
        n_prods.dly   = i_span.dly;
        n_prods.p   = sit_pkg::t_prod'(i_span.dx1) * sit_pkg::t_prod'(i_span.dx2);
        n_prods.al  = sit_pkg::t_prod'(i_span.dy1) * sit_pkg::t_prod'(i_span.ol1);
        n_prods.bl  = sit_pkg::t_prod'(i_span.dy2) * sit_pkg::t_prod'(i_span.ol2);
        n_prods.ah  = sit_pkg::t_prod'(i_span.dy1) * sit_pkg::t_prod'(i_span.oh1);
        n_prods.bh  = sit_pkg::t_prod'(i_span.dy2) * sit_pkg::t_prod'(i_span.oh2);
        n_prods.vy  = sit_pkg::t_prod'(i_span.vly) * sit_pkg::t_prod'(i_span.vdx);
        n_prods.vt  = sit_pkg::t_prod'(i_span.vdy) * sit_pkg::t_prod'(i_span.voff);
        n_prods.vlo = sit_pkg::t_prod'(i_span.vylo) * sit_pkg::t_prod'(i_span.vdx);
        n_prods.vhi = sit_pkg::t_prod'(i_span.vyhi) * sit_pkg::t_prod'(i_span.vdx);
    end

    always_comb begin
        n_wides.flags = r_prods.flags;
        n_wides.pd  = sit_pkg::t_wide'(r_prods.p)  * sit_pkg::t_wide'(r_prods.dly);
        n_wides.al2 = sit_pkg::t_wide'(r_prods.al) * sit_pkg::t_wide'(r_prods.dx2);
        n_wides.bl2 = sit_pkg::t_wide'(r_prods.bl) * sit_pkg::t_wide'(r_prods.dx1);
        n_wides.ah2 = sit_pkg::t_wide'(r_prods.ah) * sit_pkg::t_wide'(r_prods.dx2);
        n_wides.bh2 = sit_pkg::t_wide'(r_prods.bh) * sit_pkg::t_wide'(r_prods.dx1);
        n_wides.vsum = sit_pkg::t_vsum'(r_prods.vy) + sit_pkg::t_vsum'(r_prods.vt);
        n_wides.vlo = r_prods.vlo;
        n_wides.vhi = r_prods.vhi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v4 <= i_valid;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prods <= n_prods;
        r_wides <= n_wides;
    end

    assign o_valid = r_v5;
    assign o_wides = r_wides;

endmodule

@@ hw/rtl/sit_decide.sv @@
// Final stages: line differences at both range ends, span check, result select.
// Depends on sit_pkg.
`timescale 1ns / 1ps

module sit_decide (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  sit_pkg::t_wides i_wides,
    output logic            o_done,
    output logic            o_intersects
);

    logic            r_v6, r_done;
    sit_pkg::t_flags r_flags;
    sit_pkg::t_sum   r_dl, r_dr, n_dl, n_dr;
    logic            r_vhit, n_vhit;
    logic            r_hit, n_hit;
    logic            gen_hit;

    assign n_dl = sit_pkg::t_sum'(i_wides.pd) + sit_pkg::t_sum'(i_wides.al2)
                - sit_pkg::t_sum'(i_wides.bl2);
    assign n_dr = sit_pkg::t_sum'(i_wides.pd) + sit_pkg::t_sum'(i_wides.ah2)
                - sit_pkg::t_sum'(i_wides.bh2);
    assign n_vhit = (i_wides.vsum >= sit_pkg::t_vsum'(i_wides.vlo))
                 && (i_wides.vsum <= sit_pkg::t_vsum'(i_wides.vhi));

    // miss only when both ends lie strictly on the same side
    assign gen_hit = !(((r_dl > 0) && (r_dr > 0)) || ((r_dl < 0) && (r_dr < 0)));

    always_comb begin
        priority if (r_flags.disjoint) begin
            n_hit = 1'b0;
        end else if (r_flags.vert1 && r_flags.vert2) begin
            n_hit = r_flags.both_hit;
        end else if (r_flags.vert1 || r_flags.vert2) begin
            n_hit = r_vhit;
        end else begin
            n_hit = gen_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v6   <= i_valid;
            r_done <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        r_flags <= i_wides.flags;
        r_dl    <= n_dl;
        r_dr    <= n_dr;
        r_vhit  <= n_vhit;
        r_hit   <= n_hit;
    end

    assign o_done       = r_done;
    assign o_intersects = r_hit;

endmodule

@@ hw/rtl/segment_intersection_test.sv @@
// Top level of the segment intersection test.
// Depends on sit_pkg, sit_setup, sit_arith and sit_decide.
//
// Usage:
//   Drive the eight signed endpoint coordinates of segments A and B and raise
//   start for one cycle; the word is taken at that rising edge. busy is held
//   low, so a new word may be taken at every edge.
//   Each word yields one result: o_intersects is valid while o_done is high,
//   for exactly one cycle, and is 1 when the segments touch or cross.
// Pipeline: seven stages; o_done is driven by a valid chain that runs alongside
//   the data registers.
// Throughput: one word per cycle, set by the seven-stage pipeline with one
//   register level after every multiplier rank.
// Reset: synchronous, active low; clears the valid chain, so no result is
//   strobed from words in flight. Data registers are not reset.
// Output: results are strobed and cannot be held off by the receiver; each
//   result leaves the pipeline exactly once, in accept order.
`timescale 1ns / 1ps

module segment_intersection_test (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  sit_pkg::t_coord i_seg_a_x0,
    input  sit_pkg::t_coord i_seg_a_y0,
    input  sit_pkg::t_coord i_seg_a_x1,
    input  sit_pkg::t_coord i_seg_a_y1,
    input  sit_pkg::t_coord i_seg_b_x0,
    input  sit_pkg::t_coord i_seg_b_y0,
    input  sit_pkg::t_coord i_seg_b_x1,
    input  sit_pkg::t_coord i_seg_b_y1,
    output logic            o_done,
    output logic            o_intersects
);

    sit_pkg::t_segs  segs;
    sit_pkg::t_span  span;
    sit_pkg::t_wides wides;
    logic            span_valid, wides_valid;

    assign busy = 1'b0;

    assign segs.ax0 = i_seg_a_x0;
    assign segs.ay0 = i_seg_a_y0;
    assign segs.ax1 = i_seg_a_x1;
    assign segs.ay1 = i_seg_a_y1;
    assign segs.bx0 = i_seg_b_x0;
    assign segs.by0 = i_seg_b_y0;
    assign segs.bx1 = i_seg_b_x1;
    assign segs.by1 = i_seg_b_y1;

    sit_setup u_setup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_segs  (segs),
        .o_valid (span_valid),
        .o_span  (span)
    );

    sit_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (span_valid),
        .i_span  (span),
        .o_valid (wides_valid),
        .o_wides (wides)
    );

    sit_decide u_decide (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (wides_valid),
        .i_wides      (wides),
        .o_done       (o_done),
        .o_intersects (o_intersects)
    );

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for segment_intersection_test: directed and random segment pairs.
// Uses sit_pkg for the coordinate types and predicts each intersects bit with exact integer sums.
// Depends on sit_pkg and segment_intersection_test.
`timescale 1ns / 1ps

module tb;
    import sit_pkg::*;

    class crossing_ledger;
        bit hit_queue[$];
        int mismatches;
        int words;
        int results;
        int crossings;

        function longint min_l(longint a, longint b);
            return (a < b) ? a : b;
        endfunction

        function longint max_l(longint a, longint b);
            return (a > b) ? a : b;
        endfunction

        // y of the line through (lx,ly) at x, scaled by dx
        function longint line_at(longint lx, longint ly, longint dx, longint dy, longint x);
            return ly * dx + dy * (x - lx);
        endfunction

        function bit column_hit(longint vx, longint vya, longint vyb,
                                longint lx, longint ly, longint rx, longint ry);
            longint dx;
            longint y;
            dx = rx - lx;
            y  = line_at(lx, ly, dx, ry - ly, vx);
            return (y >= min_l(vya, vyb) * dx) && (y <= max_l(vya, vyb) * dx);
        endfunction

        function bit segs_touch(t_segs s);
            longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
            longint l1x, l1y, r1x, r1y, l2x, l2y, r2x, r2y;
            longint lo, hi, dx1, dy1, dx2, dy2, dl, dr;
            bit hit;
            ax0 = s.ax0; ay0 = s.ay0; ax1 = s.ax1; ay1 = s.ay1;
            bx0 = s.bx0; by0 = s.by0; bx1 = s.bx1; by1 = s.by1;
            if (ax0 <= ax1) begin
                l1x = ax0; l1y = ay0; r1x = ax1; r1y = ay1;
            end else begin
                l1x = ax1; l1y = ay1; r1x = ax0; r1y = ay0;
            end
            if (bx0 <= bx1) begin
                l2x = bx0; l2y = by0; r2x = bx1; r2y = by1;
            end else begin
                l2x = bx1; l2y = by1; r2x = bx0; r2y = by0;
            end
            lo = max_l(l1x, l2x);
            hi = min_l(r1x, r2x);
            if (lo > hi) begin
                hit = 1'b0;
            end else if (l1x == r1x) begin
                if (l2x == r2x) begin
                    hit = (l1x == l2x) &&
                          (max_l(min_l(l1y, r1y), min_l(l2y, r2y)) <=
                           min_l(max_l(l1y, r1y), max_l(l2y, r2y)));
                end else begin
                    hit = column_hit(l1x, l1y, r1y, l2x, l2y, r2x, r2y);
                end
            end else if (l2x == r2x) begin
                hit = column_hit(l2x, l2y, r2y, l1x, l1y, r1x, r1y);
            end else begin
                dx1 = r1x - l1x; dy1 = r1y - l1y;
                dx2 = r2x - l2x; dy2 = r2y - l2y;
                dl = line_at(l1x, l1y, dx1, dy1, lo) * dx2 - line_at(l2x, l2y, dx2, dy2, lo) * dx1;
                dr = line_at(l1x, l1y, dx1, dy1, hi) * dx2 - line_at(l2x, l2y, dx2, dy2, hi) * dx1;
                hit = !((dl > 0 && dr > 0) || (dl < 0 && dr < 0));
            end
            return hit;
        endfunction

        function void note_word(t_segs s);
            hit_queue.push_back(segs_touch(s));
            words++;
        endfunction

        function void check_word(logic got);
            bit want;
            if (hit_queue.size() == 0) begin
                $display("%0t: unexpected result, expected none, got intersects=%b", $time, got);
                mismatches++;
                return;
            end
            want = hit_queue.pop_front();
            results++;
            if (want)
                crossings++;
            if (got !== want) begin
                $display("%0t: intersects mismatch, expected %b, got %b", $time, want, got);
                mismatches++;
            end
        endfunction
    endclass

    logic  i_clk     = 1'b0;
    logic  i_rst_n   = 1'b0;
    logic  start     = 1'b0;
    t_segs drive_segs = '0;
    logic  busy;
    logic  o_done;
    logic  o_intersects;

    crossing_ledger ledger = new();
    int             idle_pct [4] = '{0, 53, 0, 24};

    always #4 i_clk = ~i_clk;

    segment_intersection_test dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_seg_a_x0   (drive_segs.ax0),
        .i_seg_a_y0   (drive_segs.ay0),
        .i_seg_a_x1   (drive_segs.ax1),
        .i_seg_a_y1   (drive_segs.ay1),
        .i_seg_b_x0   (drive_segs.bx0),
        .i_seg_b_y0   (drive_segs.by0),
        .i_seg_b_x1   (drive_segs.bx1),
        .i_seg_b_y1   (drive_segs.by1),
        .o_done       (o_done),
        .o_intersects (o_intersects)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy)
            ledger.note_word(drive_segs);
        if (i_rst_n && o_done)
            ledger.check_word(o_intersects);
    end

    function automatic t_segs make_segs(int ax0, int ay0, int ax1, int ay1,
                                        int bx0, int by0, int bx1, int by1);
        t_segs s;
        s.ax0 = t_coord'(ax0); s.ay0 = t_coord'(ay0);
        s.ax1 = t_coord'(ax1); s.ay1 = t_coord'(ay1);
        s.bx0 = t_coord'(bx0); s.by0 = t_coord'(by0);
        s.bx1 = t_coord'(bx1); s.by1 = t_coord'(by1);
        return s;
    endfunction

    function automatic t_coord rand_coord(int kind);
        int edges [7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
        case (kind)
            0:       return t_coord'($urandom);
            1:       return t_coord'(int'($urandom_range(16)) - 8);
            default: return t_coord'(edges[$urandom_range(6)]);
        endcase
    endfunction

    // hold start high across back-to-back words; idle with junk on the data ports
    task automatic send_word(input t_segs s, input int pct);
        while ($urandom_range(99) < pct) begin
            start      <= 1'b0;
            drive_segs <= t_segs'({$urandom, $urandom, $urandom, $urandom});
            @(posedge i_clk);
        end
        start      <= 1'b1;
        drive_segs <= s;
        do @(posedge i_clk); while (busy);
    endtask

    initial begin
        t_segs s;
        int    mode;
        int    kind;
        int    directed;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(make_segs(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768), 0);
        send_word(make_segs(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767), 0);
        send_word(make_segs(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768), 0);
        send_word(make_segs(-32768, 32767, 32767, 32766, -32768, 32766, 32767, 32767), 0);
        send_word(make_segs(-32768, 0, 32767, 0, 0, -32768, 0, 32767), 0);
        send_word(make_segs(0, 0, 10, 10, 11, 0, 20, 10), 0);
        send_word(make_segs(0, 0, 10, 10, 10, 10, 20, 0), 0);
        send_word(make_segs(10, 10, 0, 0, 10, 0, 0, 10), 0);
        send_word(make_segs(0, 0, 10, 10, 0, 1, 10, 11), 0);
        send_word(make_segs(0, 0, 10, 10, 15, 15, 5, 5), 0);
        send_word(make_segs(0, 0, 10, 0, 5, 1, 15, 1), 0);
        send_word(make_segs(5, -5, 5, 5, 0, 0, 10, 3), 0);
        send_word(make_segs(5, 20, 5, 10, 0, 0, 10, 3), 0);
        send_word(make_segs(0, 0, 10, 0, 5, 0, 5, -5), 0);
        send_word(make_segs(0, 0, 10, 0, 5, 1, 5, 7), 0);
        send_word(make_segs(3, 0, 3, 10, 3, 20, 3, 10), 0);
        send_word(make_segs(3, 0, 3, 5, 3, 6, 3, 9), 0);
        send_word(make_segs(3, 0, 3, 5, 4, 0, 4, 5), 0);
        send_word(make_segs(5, 5, 5, 5, 0, 0, 10, 10), 0);
        send_word(make_segs(5, 6, 5, 6, 0, 0, 10, 10), 0);
        send_word(make_segs(-7, 2, -7, 2, -7, 2, -7, 2), 0);
        send_word(make_segs(-7, 2, -7, 2, -7, 3, -7, 3), 0);
        send_word(make_segs(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768), 0);
        directed = ledger.words + 1;

        for (int phase = 0; phase < 4; phase++) begin
            for (int n = 0; n < 100; n++) begin
                mode = $urandom_range(9);
                kind = (mode < 3) ? 0 : (mode < 6) ? 1 : (mode == 6) ? 2 : $urandom_range(1);
                s = make_segs(rand_coord(kind), rand_coord(kind), rand_coord(kind),
                              rand_coord(kind), rand_coord(kind), rand_coord(kind),
                              rand_coord(kind), rand_coord(kind));
                case (mode)
                    7: s.ax1 = s.ax0;
                    8: begin
                        s.bx1 = s.bx0;
                        if ($urandom_range(1))
                            s.ax0 = s.bx0;
                        if ($urandom_range(1))
                            s.ax1 = s.bx0;
                    end
                    9: begin
                        s.bx0 = s.ax1;
                        s.by0 = s.ay1;
                    end
                    default: ;
                endcase
                send_word(s, idle_pct[phase]);
            end
        end
        start <= 1'b0;

        while (ledger.hit_queue.size() != 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        $display("covered %0d segment pairs (%0d directed, rest random over four idle phases)",
                 ledger.words, directed - 1);
        $display("checked %0d results, %0d of them touching or crossing",
                 ledger.results, ledger.crossings);
        if (ledger.mismatches == 0 && ledger.hit_queue.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("timeout with %0d results outstanding", ledger.hit_queue.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
